// ===== hdl/plt_pkg.sv =====
// ----------------------------------------------------------------------------
// plt_pkg - shared types and codes for the ping latency tracker
// Request kinds, result status codes, register indexes, slot entry layout
// and the request/result bundles of the shared adder.
// ----------------------------------------------------------------------------
package plt_pkg;

	localparam int IN_DATA_W  = 112; // 106 bits of fields, padded to bytes
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 344; // 337 bits of fields, padded to bytes
	localparam int OUT_USER_W = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		REQ_SEND  = 2'd0,
		REQ_TX    = 2'd1,
		REQ_REPLY = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_SENT         = 4'd0,
		ST_TX_STORED    = 4'd1,
		ST_WRONG_PROC   = 4'd2,
		ST_TX_UNKNOWN   = 4'd3,
		ST_TX_DUP       = 4'd4,
		ST_TIMED        = 4'd5,
		ST_UNTIMED      = 4'd6,
		ST_TRUNCATED    = 4'd7,
		ST_BAD_TYPE     = 4'd8,
		ST_NO_RX_TIME   = 4'd9,
		ST_UNKNOWN_REPLY = 4'd10
	} status_t;

	typedef enum logic [1:0] {
		CFG_PROCESS_TAG = 2'd0,
		CFG_PING_LIMIT  = 2'd1,
		CFG_REPLY_TYPE  = 2'd2
	} cfg_idx_t;

	// Full echo id is kept so the tag compare works for any slot count.
	typedef struct packed {
		logic        valid;
		logic        has_tx;
		logic        has_reply;
		logic [15:0] id;
	} slot_flag_t;

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic        sub;
	} alu_req_t;

	typedef struct packed {
		logic [63:0] sum;
		logic        carry;  // on subtract: a >= b
	} alu_res_t;

endpackage

// ===== hdl/ping_latency_tracker_top.sv =====
// ----------------------------------------------------------------------------
// ping_latency_tracker_top - echo request table with round-trip statistics
// Per event: table read, check, adder steps by kind, output load. No adder
// step for a timestamp or a rejected event; limit compare, sent count, next
// id for a send; answered count on a first reply; for a timed reply six more
// (difference, timed count, total, square sum, min, max). One transaction at
// a time, paced by the sequencer stepping the single shared 64-bit adder,
// plus any output stall. Reset: arst_n clears counters and statistics, then
// a clearing pass writes every slot flag word before an input is taken.
// ----------------------------------------------------------------------------
module ping_latency_tracker_top #(
	parameter int SLOT_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write port
	input  logic                              cfg_wen,
	input  logic [plt_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [plt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// event stream in
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// from bit 0: msg_id, stamp_process, time_ns, packet_type, too_short,
	// rx_time_valid, zero pad
	input  logic [plt_pkg::IN_DATA_W-1:0]     s_tdata,
	// req_type
	input  logic [plt_pkg::IN_USER_W-1:0]     s_tuser,
	// result stream out
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// from bit 0: echo_id, rtt_ns, limit_reached, pings_sent, pongs_timed,
	// pings_answered, rtt_min_ns, rtt_max_ns, rtt_total_ns, rtt_square_total,
	// zero pad
	output logic [plt_pkg::OUT_DATA_W-1:0]    m_tdata,
	// status
	output logic [plt_pkg::OUT_USER_W-1:0]    m_tuser
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD, S_CHK, S_LIMIT, S_CNT, S_NID, S_ANS,
		S_DIFF, S_TCNT, S_TOTAL, S_SQ, S_MIN, S_MAX, S_DONE
	} state_t;

	state_t state_q;
	logic [SLOT_BITS-1:0] clr_q;

	// config registers
	logic [15:0] proc_tag_q;
	logic [31:0] limit_cfg_q;
	logic [7:0]  reply_code_q;

	// latched event
	plt_pkg::req_t req_q;
	logic [15:0] id_q;
	logic [15:0] proc_q;
	logic [63:0] time_q;
	logic [7:0]  ptype_q;
	logic        short_q;
	logic        rxv_q;

	// persistent state and statistics
	logic [15:0] next_id_q;
	logic [31:0] sent_q;
	logic [31:0] timed_q;
	logic [31:0] ans_q;
	logic [31:0] min_q;
	logic [31:0] max_q;
	logic [63:0] total_q;
	logic [63:0] sqsum_q;

	// per-event result
	plt_pkg::status_t status_q;
	logic [15:0] echo_q;
	logic [31:0] rtt_q;
	logic        limit_q;
	logic        has_tx_q;
	logic [63:0] sq_q;

	// output register
	logic                           m_tvalid_q;
	logic [plt_pkg::OUT_DATA_W-1:0] m_tdata_q;
	plt_pkg::status_t               m_tuser_q;

	// table and adder hookup
	logic [SLOT_BITS-1:0] rd_addr;
	logic [SLOT_BITS-1:0] wr_addr;
	logic                 flag_we;
	plt_pkg::slot_flag_t  flag_wdata;
	logic                 time_we;
	plt_pkg::slot_flag_t  flag_rd;
	logic [63:0]          time_rd;
	plt_pkg::alu_req_t    alu_req;
	plt_pkg::alu_res_t    alu_res;

	logic entry_hit;
	logic s_fire;

	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// An entry matches only if valid and it was opened for this exact id.
	assign entry_hit = flag_rd.valid && (flag_rd.id == id_q);
	assign rd_addr   = id_q[SLOT_BITS-1:0];

	plt_slot_table #(.SLOT_BITS(SLOT_BITS)) u_table (
		.clk        (clk),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.flag_we    (flag_we),
		.flag_wdata (flag_wdata),
		.time_we    (time_we),
		.time_wdata (time_q),
		.flag_rdata (flag_rd),
		.time_rdata (time_rd)
	);

	plt_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	// Table writes: clearing sweep, opening a slot on send, marking tx/reply.
	always_comb begin
		flag_we    = 1'b0;
		time_we    = 1'b0;
		wr_addr    = id_q[SLOT_BITS-1:0];
		flag_wdata = flag_rd;
		case (state_q)
			S_CLEAR: begin
				flag_we    = 1'b1;
				wr_addr    = clr_q;
				flag_wdata = '0;
			end
			S_CHK: begin
				case (req_q)
					plt_pkg::REQ_SEND: begin
						flag_we    = 1'b1;
						wr_addr    = next_id_q[SLOT_BITS-1:0];
						flag_wdata = '{valid: 1'b1, has_tx: 1'b0, has_reply: 1'b0,
							id: next_id_q};
					end
					plt_pkg::REQ_TX: begin
						if (proc_q == proc_tag_q && entry_hit && !flag_rd.has_tx) begin
							flag_we           = 1'b1;
							time_we           = 1'b1;
							flag_wdata.has_tx = 1'b1;
						end
					end
					plt_pkg::REQ_REPLY: begin
						if (!short_q && ptype_q == reply_code_q && rxv_q && entry_hit
							&& !flag_rd.has_reply) begin
							flag_we              = 1'b1;
							flag_wdata.has_reply = 1'b1;
						end
					end
					default: begin
						flag_we = 1'b0;
					end
				endcase
			end
			default: begin
				flag_we = 1'b0;
			end
		endcase
	end

	// Operand select for the shared adder, one step per sequencer state.
	always_comb begin
		alu_req = '0;
		case (state_q)
			S_LIMIT: alu_req = '{a: {32'd0, sent_q}, b: {32'd0, limit_cfg_q}, sub: 1'b1};
			S_CNT:   alu_req = '{a: {32'd0, sent_q}, b: 64'd1, sub: 1'b0};
			S_NID:   alu_req = '{a: {48'd0, next_id_q}, b: 64'd1, sub: 1'b0};
			S_ANS:   alu_req = '{a: {32'd0, ans_q}, b: 64'd1, sub: 1'b0};
			S_DIFF:  alu_req = '{a: time_q, b: time_rd, sub: 1'b1};
			S_TCNT:  alu_req = '{a: {32'd0, timed_q}, b: 64'd1, sub: 1'b0};
			S_TOTAL: alu_req = '{a: total_q, b: {32'd0, rtt_q}, sub: 1'b0};
			S_SQ:    alu_req = '{a: sqsum_q, b: sq_q, sub: 1'b0};
			S_MIN:   alu_req = '{a: {32'd0, rtt_q}, b: {32'd0, min_q}, sub: 1'b1};
			S_MAX:   alu_req = '{a: {32'd0, max_q}, b: {32'd0, rtt_q}, sub: 1'b1};
			default: alu_req = '0;
		endcase
	end

	// Square of the clamped rtt; ready one step before the sum needs it.
	always_ff @(posedge clk) begin
		sq_q <= 64'(rtt_q) * 64'(rtt_q);
	end

	// Sequencer, statistics and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			proc_tag_q   <= '0;
			limit_cfg_q  <= '0;
			reply_code_q <= 8'd2;
			next_id_q    <= '0;
			sent_q       <= '0;
			timed_q      <= '0;
			ans_q        <= '0;
			min_q        <= '1;
			max_q        <= '0;
			total_q      <= '0;
			sqsum_q      <= '0;
			m_tvalid_q   <= 1'b0;
			req_q        <= plt_pkg::REQ_NONE;
			status_q     <= plt_pkg::ST_SENT;
			m_tuser_q    <= plt_pkg::ST_SENT;
		end else begin
			// config writes are taken in any state
			if (cfg_wen) begin
				case (cfg_idx)
					plt_pkg::CFG_PROCESS_TAG: proc_tag_q   <= cfg_wdata[15:0];
					plt_pkg::CFG_PING_LIMIT:  limit_cfg_q  <= cfg_wdata;
					plt_pkg::CFG_REPLY_TYPE:  reply_code_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end

			// drop the result once the sink takes it
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_fire) begin
						req_q   <= plt_pkg::req_t'(s_tuser);
						id_q    <= s_tdata[15:0];
						proc_q  <= s_tdata[31:16];
						time_q  <= s_tdata[95:32];
						ptype_q <= s_tdata[103:96];
						short_q <= s_tdata[104];
						rxv_q   <= s_tdata[105];
						rtt_q   <= '0;
						limit_q <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					// the addressed slot is read here; the registered data is used in S_CHK
					state_q <= S_CHK;
				end
				S_CHK: begin
					echo_q   <= id_q;
					has_tx_q <= flag_rd.has_tx;
					state_q  <= S_DONE;
					case (req_q)
						plt_pkg::REQ_SEND: begin
							echo_q   <= next_id_q;
							status_q <= plt_pkg::ST_SENT;
							state_q  <= S_LIMIT;
						end
						plt_pkg::REQ_TX: begin
							if (proc_q != proc_tag_q) begin
								status_q <= plt_pkg::ST_WRONG_PROC;
							end else if (!entry_hit) begin
								status_q <= plt_pkg::ST_TX_UNKNOWN;
							end else if (flag_rd.has_tx) begin
								status_q <= plt_pkg::ST_TX_DUP;
							end else begin
								status_q <= plt_pkg::ST_TX_STORED;
							end
						end
						plt_pkg::REQ_REPLY: begin
							if (short_q) begin
								status_q <= plt_pkg::ST_TRUNCATED;
							end else if (ptype_q != reply_code_q) begin
								status_q <= plt_pkg::ST_BAD_TYPE;
							end else if (!rxv_q) begin
								status_q <= plt_pkg::ST_NO_RX_TIME;
							end else if (!entry_hit) begin
								status_q <= plt_pkg::ST_UNKNOWN_REPLY;
							end else begin
								status_q <= flag_rd.has_tx ? plt_pkg::ST_TIMED
									: plt_pkg::ST_UNTIMED;
								if (!flag_rd.has_reply) begin
									state_q <= S_ANS;
								end else if (flag_rd.has_tx) begin
									state_q <= S_DIFF;
								end
							end
						end
						default: begin
							// unused selector: no result
							state_q <= S_IDLE;
						end
					endcase
				end
				S_LIMIT: begin
					limit_q <= (limit_cfg_q != '0) && alu_res.carry;
					state_q <= S_CNT;
				end
				S_CNT: begin
					sent_q  <= alu_res.sum[31:0];
					state_q <= S_NID;
				end
				S_NID: begin
					next_id_q <= alu_res.sum[15:0];
					state_q   <= S_DONE;
				end
				S_ANS: begin
					ans_q   <= alu_res.sum[31:0];
					state_q <= has_tx_q ? S_DIFF : S_DONE;
				end
				S_DIFF: begin
					// rx not after tx gives zero; clamp to 32 bits
					if (!alu_res.carry) begin
						rtt_q <= '0;
					end else if (|alu_res.sum[63:32]) begin
						rtt_q <= '1;
					end else begin
						rtt_q <= alu_res.sum[31:0];
					end
					state_q <= S_TCNT;
				end
				S_TCNT: begin
					timed_q <= alu_res.sum[31:0];
					state_q <= S_TOTAL;
				end
				S_TOTAL: begin
					total_q <= alu_res.sum;
					state_q <= S_SQ;
				end
				S_SQ: begin
					sqsum_q <= alu_res.carry ? '1 : alu_res.sum;
					state_q <= S_MIN;
				end
				S_MIN: begin
					if (!alu_res.carry) begin
						min_q <= rtt_q;
					end
					state_q <= S_MAX;
				end
				S_MAX: begin
					if (!alu_res.carry) begin
						max_q <= rtt_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= status_q;
						m_tdata_q  <= {7'd0, sqsum_q, total_q, max_q, min_q, ans_q,
							timed_q, sent_q, limit_q, rtt_q, echo_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/plt_alu.sv =====
// ----------------------------------------------------------------------------
// plt_alu - shared 64-bit add/subtract unit
// Serves every count, sum, difference and compare step of the sequencer.
// ----------------------------------------------------------------------------
module plt_alu (
	input  plt_pkg::alu_req_t req,
	output plt_pkg::alu_res_t res
);

	logic [63:0] b_op;
	logic [64:0] full;

	assign b_op = req.sub ? ~req.b : req.b;
	assign full = {1'b0, req.a} + {1'b0, b_op} + {64'd0, req.sub};
	assign res.sum   = full[63:0];
	assign res.carry = full[64];

endmodule

// ===== hdl/plt_slot_table.sv =====
// ----------------------------------------------------------------------------
// plt_slot_table - outstanding request table
// Flag words and tx timestamps, one entry per slot, registered reads.
// ----------------------------------------------------------------------------
module plt_slot_table #(
	parameter int SLOT_BITS = 8
) (
	input  logic                 clk,
	input  logic [SLOT_BITS-1:0] rd_addr,
	input  logic [SLOT_BITS-1:0] wr_addr,
	input  logic                 flag_we,
	input  plt_pkg::slot_flag_t  flag_wdata,
	input  logic                 time_we,
	input  logic [63:0]          time_wdata,
	output plt_pkg::slot_flag_t  flag_rdata,
	output logic [63:0]          time_rdata
);

	localparam int DEPTH = 1 << SLOT_BITS;

	plt_pkg::slot_flag_t flag_mem [DEPTH];
	logic [63:0]         time_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (flag_we) begin
			flag_mem[wr_addr] <= flag_wdata;
		end
		flag_rdata <= flag_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (time_we) begin
			time_mem[wr_addr] <= time_wdata;
		end
		time_rdata <= time_mem[rd_addr];
	end

endmodule

// ===== hdl/plt_checker.sv =====
// ----------------------------------------------------------------------------
// plt_checker - port-level checks for the ping latency tracker
// Watches both streams and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module plt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [plt_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [plt_pkg::OUT_USER_W-1:0] m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// the block is busy right after taking an event
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("event taken while previous one in progress");

	// only a timed reply carries a round-trip time
	a_rtt_only_timed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != plt_pkg::ST_TIMED |-> m_tdata[47:16] == 32'd0)
		else $error("rtt on a result that is not a timed reply");

	// limit flag only on a send
	a_limit_only_send: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != plt_pkg::ST_SENT |-> !m_tdata[48])
		else $error("limit flag on a result that is not a send");

endmodule

bind ping_latency_tracker_top plt_checker u_plt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
